>>> rtl/iir_direct_form2_filter_top_assert.svh
// Assertion macros for the IIR filter; clock clk_i, reset rst_ni.
`ifndef IIR_DIRECT_FORM2_FILTER_TOP_ASSERT_SVH
`define IIR_DIRECT_FORM2_FILTER_TOP_ASSERT_SVH

// Checked only while out of reset.
`define IIRDF2_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Checked on every edge, also during reset.
`define IIRDF2_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error(msg);

`endif

>>> rtl/iirdf2_pkg.sv
`default_nettype none

package iirdf2_pkg;

  localparam int unsigned SAMPLE_BITS_DEF    = 24;
  localparam int unsigned COEF_FRAC_BITS_DEF = 16;

  localparam int unsigned COEF_W     = 20;
  localparam int unsigned DELAY_W    = 32;
  localparam int unsigned ORDER_W    = 2;
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 20;
  localparam int unsigned COEF_SEL_W = 3;

  // Register indexes of the configuration channel
  localparam logic [CFG_IDX_W-1:0] REG_ORDER = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_A1    = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_A2    = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_A3    = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_B0    = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_B1    = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_B2    = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_B3    = 4'd7;

  localparam logic [ORDER_W-1:0]       ORDER_RESET = 2'd2;
  localparam logic signed [COEF_W-1:0] COEF_ONE    = 20'sd65536;

  typedef enum logic [2:0] {
    ACC_HOLD,
    ACC_LOAD_X,
    ACC_CLEAR,
    ACC_SUB,
    ACC_ADD
  } acc_op_e;

  typedef enum logic [1:0] {
    DAT_W1,
    DAT_W2,
    DAT_W3,
    DAT_V
  } dat_sel_e;

  typedef enum logic [1:0] {
    OUT_NONE,
    OUT_Y,
    OUT_X
  } out_src_e;

  typedef enum logic [1:0] {
    FLOW_NEXT,
    FLOW_JMP_ORD0,
    FLOW_DONE
  } flow_e;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } seq_state_e;

  localparam int unsigned PC_W     = 4;
  localparam int unsigned PROG_LEN = 11;

  localparam logic [PC_W-1:0] PC_START  = 4'd0;
  localparam logic [PC_W-1:0] PC_BYPASS = 4'd10;
  localparam logic [PC_W-1:0] PC_LAST   = 4'd10;

  typedef struct packed {
    acc_op_e                 acc_op;
    logic [ORDER_W-1:0]      need;     // lowest order at which the add/sub applies
    logic                    mul_en;
    logic [CFG_IDX_W-1:0]    coef;
    dat_sel_e                dat;
    logic                    sat_v;
    out_src_e                out_src;
    flow_e                   flow;
    logic [PC_W-1:0]         target;
  } ctl_word_t;

  // The add/sub of a step consumes the product started by the step before.
  localparam ctl_word_t PROG [PROG_LEN] = '{
    '{ACC_LOAD_X, 2'd0, 1'b1, REG_A1,    DAT_W1, 1'b0, OUT_NONE, FLOW_JMP_ORD0, PC_BYPASS},
    '{ACC_SUB,    2'd1, 1'b1, REG_A2,    DAT_W2, 1'b0, OUT_NONE, FLOW_NEXT,     PC_START},
    '{ACC_SUB,    2'd2, 1'b1, REG_A3,    DAT_W3, 1'b0, OUT_NONE, FLOW_NEXT,     PC_START},
    '{ACC_SUB,    2'd3, 1'b0, REG_ORDER, DAT_W1, 1'b0, OUT_NONE, FLOW_NEXT,     PC_START},
    '{ACC_CLEAR,  2'd0, 1'b1, REG_B1,    DAT_W1, 1'b1, OUT_NONE, FLOW_NEXT,     PC_START},
    '{ACC_ADD,    2'd1, 1'b1, REG_B0,    DAT_V,  1'b0, OUT_NONE, FLOW_NEXT,     PC_START},
    '{ACC_ADD,    2'd0, 1'b1, REG_B2,    DAT_W2, 1'b0, OUT_NONE, FLOW_NEXT,     PC_START},
    '{ACC_ADD,    2'd2, 1'b1, REG_B3,    DAT_W3, 1'b0, OUT_NONE, FLOW_NEXT,     PC_START},
    '{ACC_ADD,    2'd3, 1'b0, REG_ORDER, DAT_W1, 1'b0, OUT_NONE, FLOW_NEXT,     PC_START},
    '{ACC_HOLD,   2'd0, 1'b0, REG_ORDER, DAT_W1, 1'b0, OUT_Y,    FLOW_DONE,     PC_START},
    '{ACC_HOLD,   2'd0, 1'b0, REG_ORDER, DAT_W1, 1'b0, OUT_X,    FLOW_DONE,     PC_START}
  };

endpackage

`default_nettype wire

>>> rtl/iir_direct_form2_filter_top.sv
// A new sample is taken only once the last one is in the output register; bypass (order 0)
//   jumps from the first step to the final one. One shared multiplier steps through the
//   seven products under a microcode table.
// A full output register stalls the final step until the word is taken.
// Reset: order 2, b0 one, other coefficients and all delays zero, output empty.
`default_nettype none
`include "iir_direct_form2_filter_top_assert.svh"

module iir_direct_form2_filter_top #(
  parameter int unsigned SAMPLE_BITS    = iirdf2_pkg::SAMPLE_BITS_DEF,
  parameter int unsigned COEF_FRAC_BITS = iirdf2_pkg::COEF_FRAC_BITS_DEF
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  // tdata: sample_in [SAMPLE_BITS-1:0], zero padded to whole bytes
  input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0]      s_axis_tdata,
  input  wire logic                                  s_axis_tlast,   // block_end_in
  input  wire logic                                  s_axis_tvalid,
  output logic                                       s_axis_tready,
  // tdata: sample_out [SAMPLE_BITS-1:0], zero padded to whole bytes
  output logic [((SAMPLE_BITS+7)/8)*8-1:0]           m_axis_tdata,
  output logic                                       m_axis_tlast,   // block_end_out
  output logic                                       m_axis_tvalid,
  input  wire logic                                  m_axis_tready,
  input  wire logic                                  cfg_valid_i,
  output logic                                       cfg_ready_o,
  input  wire logic [iirdf2_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  wire logic [iirdf2_pkg::CFG_DATA_W-1:0]     cfg_data_i
);
  import iirdf2_pkg::*;

  localparam int unsigned TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int unsigned MUL_W   = COEF_W + DELAY_W;
  localparam int unsigned PROD_W  = MUL_W - COEF_FRAC_BITS;
  localparam int unsigned MAX_A   = (PROD_W > SAMPLE_BITS) ? PROD_W : SAMPLE_BITS;
  localparam int unsigned ACC_W   = ((MAX_A > DELAY_W) ? MAX_A : DELAY_W) + 3;

  seq_state_e state_q, state_d;
  logic [PC_W-1:0] pc_q, pc_d;
  ctl_word_t ctl;

  logic [ORDER_W-1:0]       order_q;
  logic signed [COEF_W-1:0] coef_q [1:7];

  logic signed [SAMPLE_BITS-1:0] x_q;
  logic                          last_q;
  logic signed [DELAY_W-1:0]     w1_q, w2_q, w3_q, v_q;
  logic signed [PROD_W-1:0]      prod_q;
  logic signed [ACC_W-1:0]       acc_q, acc_d;

  logic signed [SAMPLE_BITS-1:0] out_sample_q;
  logic                          out_last_q, out_valid_q;

  logic                          in_acc, step_en, out_load, term_on;
  logic signed [COEF_W-1:0]      mul_coef;
  logic signed [DELAY_W-1:0]     mul_dat;
  logic signed [MUL_W-1:0]       mul_full;
  logic signed [DELAY_W-1:0]     v_sat;
  logic signed [SAMPLE_BITS-1:0] y_sat;
  logic [ACC_W-DELAY_W:0]        v_hi;
  logic [ACC_W-SAMPLE_BITS:0]    y_hi;

  assign ctl = PROG[pc_q];

  // ---------------- Configuration ----------------
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_q          <= ORDER_RESET;
      coef_q[REG_A1[COEF_SEL_W-1:0]] <= '0;
      coef_q[REG_A2[COEF_SEL_W-1:0]] <= '0;
      coef_q[REG_A3[COEF_SEL_W-1:0]] <= '0;
      coef_q[REG_B0[COEF_SEL_W-1:0]] <= COEF_ONE;
      coef_q[REG_B1[COEF_SEL_W-1:0]] <= '0;
      coef_q[REG_B2[COEF_SEL_W-1:0]] <= '0;
      coef_q[REG_B3[COEF_SEL_W-1:0]] <= '0;
    end else if (cfg_valid_i) begin
      priority if (cfg_index_i == REG_ORDER) begin
        order_q <= cfg_data_i[ORDER_W-1:0];
      end else if (cfg_index_i <= REG_B3) begin
        coef_q[cfg_index_i[COEF_SEL_W-1:0]] <= $signed(cfg_data_i[COEF_W-1:0]);
      end else begin
        // drop writes beyond the register list
      end
    end
  end

  // ---------------- Sequencer ----------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_acc) state_d = ST_RUN;
      ST_RUN:  if (out_load) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = (state_q == ST_IDLE);
    in_acc        = s_axis_tvalid && s_axis_tready;
    // hold the final step while the output register is still full
    step_en       = (state_q == ST_RUN) &&
                    !(ctl.flow == FLOW_DONE && out_valid_q && !m_axis_tready);
    out_load      = step_en && (ctl.flow == FLOW_DONE);
    term_on       = (ctl.need <= order_q);
    pc_d          = pc_q;
    if (in_acc) begin
      pc_d = PC_START;
    end else if (step_en) begin
      if (ctl.flow == FLOW_JMP_ORD0 && order_q == '0) begin
        pc_d = ctl.target;
      end else if (ctl.flow != FLOW_DONE) begin
        pc_d = pc_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pc_q    <= PC_START;
    end else begin
      state_q <= state_d;
      pc_q    <= pc_d;
    end
  end

  // ---------------- Datapath ----------------
  always_comb begin
    mul_coef = coef_q[ctl.coef[COEF_SEL_W-1:0]];
    unique case (ctl.dat)
      DAT_W1:  mul_dat = w1_q;
      DAT_W2:  mul_dat = w2_q;
      DAT_W3:  mul_dat = w3_q;
      DAT_V:   mul_dat = v_q;
      default: mul_dat = w1_q;
    endcase
    mul_full = MUL_W'(mul_coef) * MUL_W'(mul_dat);
  end

  always_comb begin
    acc_d = acc_q;
    unique case (ctl.acc_op)
      ACC_HOLD:   acc_d = acc_q;
      ACC_LOAD_X: acc_d = ACC_W'(x_q);
      ACC_CLEAR:  acc_d = '0;
      ACC_SUB:    if (term_on) acc_d = acc_q - ACC_W'(prod_q);
      ACC_ADD:    if (term_on) acc_d = acc_q + ACC_W'(prod_q);
      default:    acc_d = acc_q;
    endcase
  end

  // saturate: in range when all bits above the target sign bit match it
  always_comb begin
    v_hi = acc_q[ACC_W-1:DELAY_W-1];
    if (&v_hi || ~|v_hi) begin
      v_sat = acc_q[DELAY_W-1:0];
    end else begin
      v_sat = {acc_q[ACC_W-1], {(DELAY_W-1){~acc_q[ACC_W-1]}}};
    end
    y_hi = acc_q[ACC_W-1:SAMPLE_BITS-1];
    if (&y_hi || ~|y_hi) begin
      y_sat = acc_q[SAMPLE_BITS-1:0];
    end else begin
      y_sat = {acc_q[ACC_W-1], {(SAMPLE_BITS-1){~acc_q[ACC_W-1]}}};
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      x_q    <= $signed(s_axis_tdata[SAMPLE_BITS-1:0]);
      last_q <= s_axis_tlast;
    end
    if (step_en) begin
      acc_q <= acc_d;
      if (ctl.mul_en) prod_q <= mul_full[MUL_W-1:COEF_FRAC_BITS];
      if (ctl.sat_v)  v_q    <= v_sat;
    end
  end

  // advance the delay line only on a filtered sample, and only the taps in use
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w1_q <= '0;
      w2_q <= '0;
      w3_q <= '0;
    end else if (out_load && ctl.out_src == OUT_Y) begin
      w1_q <= v_q;
      if (order_q >= 2'd2) w2_q <= w1_q;
      if (order_q == 2'd3) w3_q <= w2_q;
    end
  end

  // ---------------- Output register ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_sample_q <= (ctl.out_src == OUT_X) ? x_q : y_sat;
      out_last_q   <= last_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = TDATA_W'($unsigned(out_sample_q));

  // ---------------- Assertions ----------------
  `IIRDF2_ASSERT(a_start_at_zero, (s_axis_tvalid && s_axis_tready) |=> (state_q == ST_RUN && pc_q == PC_START), "sequencer did not start at step zero")
  `IIRDF2_ASSERT(a_pc_in_program, (state_q == ST_RUN) |-> (pc_q <= PC_LAST), "step counter left the program")
  `IIRDF2_ASSERT_ALWAYS(a_no_overwrite, out_load |-> (!out_valid_q || m_axis_tready), "output word overwritten")
  `IIRDF2_ASSERT(a_bypass_keeps_delay, (state_q == ST_RUN && order_q == '0) |=> ($stable(w1_q) && $stable(w2_q) && $stable(w3_q)), "bypass changed the delay line")

endmodule

`default_nettype wire
